/* rtl/kfq_pkg.sv */
// keyed fifo queue: shared types, sizes, command and status codes
// no dependencies; used by every module in rtl/
`default_nettype none

package kfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 16;

  localparam int WORD_BITS   = 16;
  localparam int NEXT_BITS   = 17;
  localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int TREE_LEVELS = $clog2(QUEUE_DEPTH);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int LVL_BITS    = $clog2(TREE_LEVELS + 1);

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_SERVE   = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_NEXT_ID = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_TREE,
    FSM_OUT
  } fsm_t;

  // contents of one slot
  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [WORD_BITS-1:0] patient;
    logic [WORD_BITS-1:0] doctor;
  } slot_t;

  // broadcast control from the command decoder to every cell
  typedef struct packed {
    logic                 insert_en;
    logic                 cancel_en;
    logic                 clear_en;
    logic [KEY_BITS-1:0]  key;
    logic [WORD_BITS-1:0] patient;
    logic [WORD_BITS-1:0] doctor;
  } cell_ctrl_t;

  function automatic logic [KEY_BITS-1:0] key_max(input logic [KEY_BITS-1:0] a,
                                                  input logic [KEY_BITS-1:0] b);
    key_max = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

/* rtl/keyed_fifo_queue_core.sv */
// keyed fifo queue with removal by key, built as a chain of slot cells
// a command changes the cells at its accept edge; the result beat is loaded into the
// output register once the registered max tree behind next_key has settled
// a new command is taken only after the previous result is loaded; a stalled result beat
// holds the next one back until it is taken
// reset: rst empties the queue (slot valid flags and count); slot payload is not cleared
`default_nettype none

module keyed_fifo_queue_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [15:0] entry_key,
  input  wire logic [15:0] patient_number,
  input  wire logic [15:0] doctor_number,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             success,
  output logic [2:0]       status_code,
  output logic [15:0]      head_key,
  output logic [15:0]      head_patient,
  output logic [15:0]      head_doctor,
  output logic [16:0]      next_key,
  output logic [4:0]       occupancy
);

  localparam int D = kfq_pkg::QUEUE_DEPTH;

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  kfq_pkg::fsm_t                  state, state_next;
  logic [kfq_pkg::LVL_BITS-1:0]   lvl, lvl_next;
  logic [kfq_pkg::OCC_BITS-1:0]   count, count_next;
  logic                           in_accept;
  logic                           out_load;

  // ---------------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------------
  kfq_pkg::cell_ctrl_t            ctrl;
  kfq_pkg::slot_t                 slots [D];
  kfq_pkg::slot_t                 nbr_slots [D];
  logic                           shift_chain [D+1];
  logic [D-1:0]                   match_vec;
  logic [D-1:0]                   valid_vec;
  logic [kfq_pkg::KEY_BITS-1:0]   leaf_keys [D];
  logic [kfq_pkg::KEY_BITS-1:0]   max_key;
  logic                           serve_en;

  // decoded command
  logic [kfq_pkg::KEY_BITS-1:0]   key_in;
  logic                           found;
  logic                           full;
  logic                           empty;
  logic                           cmd_ok;
  kfq_pkg::status_t               cmd_status;
  logic                           take_head;
  logic                           insert_go;
  logic                           cancel_go;
  logic                           serve_go;
  logic                           clear_go;

  // result held while the max tree settles
  logic                           res_success;
  kfq_pkg::status_t               res_status;
  logic [15:0]                    res_head_key;
  logic [15:0]                    res_head_patient;
  logic [15:0]                    res_head_doctor;
  logic [kfq_pkg::OCC_BITS-1:0]   res_occupancy;

  assign in_accept = in_valid && !in_stall;
  assign key_in    = kfq_pkg::KEY_BITS'(entry_key);
  assign found     = |match_vec;
  assign full      = valid_vec[D-1];
  assign empty     = !valid_vec[0];

  // command decode: only the outcome, gated by accept below
  always_comb begin
    cmd_ok     = 1'b0;
    cmd_status = kfq_pkg::ST_OK;
    take_head  = 1'b0;
    insert_go  = 1'b0;
    cancel_go  = 1'b0;
    serve_go   = 1'b0;
    clear_go   = 1'b0;
    unique case (kfq_pkg::cmd_t'(command))
      kfq_pkg::CMD_INSERT: begin
        // duplicate check wins over the full check
        if (found) begin
          cmd_status = kfq_pkg::ST_DUPLICATE;
        end else if (full) begin
          cmd_status = kfq_pkg::ST_FULL;
        end else begin
          cmd_ok    = 1'b1;
          insert_go = 1'b1;
        end
      end
      kfq_pkg::CMD_CANCEL: begin
        if (found) begin
          cmd_ok    = 1'b1;
          cancel_go = 1'b1;
        end else begin
          cmd_status = kfq_pkg::ST_NOT_FOUND;
        end
      end
      kfq_pkg::CMD_PEEK, kfq_pkg::CMD_SERVE: begin
        if (empty) begin
          cmd_status = kfq_pkg::ST_EMPTY;
        end else begin
          cmd_ok    = 1'b1;
          take_head = 1'b1;
          serve_go  = (kfq_pkg::cmd_t'(command) == kfq_pkg::CMD_SERVE);
        end
      end
      kfq_pkg::CMD_CLEAR: begin
        cmd_ok   = 1'b1;
        clear_go = 1'b1;
      end
      kfq_pkg::CMD_NEXT_ID: begin
        cmd_ok = 1'b1;
      end
      default: begin
        // unused codes leave everything as is
        cmd_ok = 1'b0;
      end
    endcase
  end

  // broadcast to the cells, only on an accepted beat
  assign ctrl = '{
    insert_en: in_accept && insert_go,
    cancel_en: in_accept && cancel_go,
    clear_en:  in_accept && clear_go,
    key:       key_in,
    patient:   patient_number,
    doctor:    doctor_number
  };
  assign serve_en = in_accept && serve_go;

  // new occupancy after the command
  always_comb begin
    count_next = count;
    if (in_accept) begin
      if (clear_go) begin
        count_next = '0;
      end else if (insert_go) begin
        count_next = count + kfq_pkg::OCC_BITS'(1);
      end else if (cancel_go || serve_go) begin
        count_next = count - kfq_pkg::OCC_BITS'(1);
      end
    end
  end

  assign shift_chain[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      // each cell pulls from its right neighbor; the last one pulls an empty slot
      if (i < D - 1) begin : g_nbr
        assign nbr_slots[i] = slots[i+1];
      end else begin : g_tail
        assign nbr_slots[i] = '0;
      end

      kfq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .serve_seed ((i == 0) ? serve_en : 1'b0),
        .shift_in   (shift_chain[i]),
        .prev_valid ((i == 0) ? 1'b1 : valid_vec[(i == 0) ? 0 : i-1]),
        .nbr        (nbr_slots[i]),
        .slot       (slots[i]),
        .match      (match_vec[i]),
        .shift_out  (shift_chain[i+1])
      );

      assign valid_vec[i] = slots[i].valid;
      // empty slots count as key zero, which also gives 1 for an empty queue
      assign leaf_keys[i] = slots[i].valid ? slots[i].key : '0;
    end
  endgenerate

  kfq_max_tree u_max_tree (
    .clk       (clk),
    .leaf_keys (leaf_keys),
    .max_key   (max_key)
  );

  // ---------------------------------------------------------------------------
  // sequencer: accept, wait for the tree, hand the beat to the output register
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    unique case (state)
      kfq_pkg::FSM_IDLE: begin
        if (in_accept) begin
          state_next = kfq_pkg::FSM_TREE;
          lvl_next   = '0;
        end
      end
      kfq_pkg::FSM_TREE: begin
        lvl_next = lvl + kfq_pkg::LVL_BITS'(1);
        if (lvl == kfq_pkg::LVL_BITS'(kfq_pkg::TREE_LEVELS - 1)) begin
          state_next = kfq_pkg::FSM_OUT;
        end
      end
      kfq_pkg::FSM_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = kfq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = kfq_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state)
      kfq_pkg::FSM_IDLE: in_stall = 1'b0;
      kfq_pkg::FSM_TREE: in_stall = 1'b1;
      kfq_pkg::FSM_OUT:  out_load = !out_valid || !out_stall;
      default:           in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfq_pkg::FSM_IDLE;
      lvl   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      count <= count_next;
    end
  end

  // per-command result captured at accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_success      <= cmd_ok;
      res_status       <= cmd_status;
      res_head_key     <= take_head ? 16'(slots[0].key) : '0;
      res_head_patient <= take_head ? slots[0].patient : '0;
      res_head_doctor  <= take_head ? slots[0].doctor : '0;
      res_occupancy    <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      success      <= res_success;
      status_code  <= res_status;
      head_key     <= res_head_key;
      head_patient <= res_head_patient;
      head_doctor  <= res_head_doctor;
      next_key     <= kfq_pkg::NEXT_BITS'(max_key) + kfq_pkg::NEXT_BITS'(1);
      occupancy    <= 5'(res_occupancy);
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_count_matches_cells: assert property (
    @(posedge clk) disable iff (rst)
    count == kfq_pkg::OCC_BITS'($countones(valid_vec))
  ) else $error("entry count differs from occupied cells");

  a_cells_packed: assert property (
    @(posedge clk) disable iff (rst)
    ((valid_vec + D'(1)) & valid_vec) == '0
  ) else $error("occupied cells are not packed at the head");

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    in_accept |=> in_stall
  ) else $error("command accepted while the previous one is in flight");

  a_load_after_tree: assert property (
    @(posedge clk) disable iff (rst)
    out_load |-> $past(state) != kfq_pkg::FSM_IDLE
  ) else $error("result loaded before the max tree settled");

endmodule

`default_nettype wire

/* rtl/kfq_cell.sv */
// keyed fifo queue: one slot cell of the chain
// depends on kfq_pkg
`default_nettype none

module kfq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kfq_pkg::cell_ctrl_t ctrl,
  input  wire logic               serve_seed,
  input  wire logic               shift_in,
  input  wire logic               prev_valid,
  input  wire kfq_pkg::slot_t     nbr,
  output kfq_pkg::slot_t          slot,
  output logic                    match,
  output logic                    shift_out
);

  logic                          valid;
  logic [kfq_pkg::KEY_BITS-1:0]  key;
  logic [kfq_pkg::WORD_BITS-1:0] patient;
  logic [kfq_pkg::WORD_BITS-1:0] doctor;
  logic                          load;

  assign match     = valid && (key == ctrl.key);
  // once a slot is removed, every slot behind it moves up by one
  assign shift_out = shift_in | (ctrl.cancel_en & match) | serve_seed;
  // new entry lands in the first empty slot
  assign load      = ctrl.insert_en && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear_en) begin
      valid <= 1'b0;
    end else if (shift_out) begin
      valid <= nbr.valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_out) begin
      key     <= nbr.key;
      patient <= nbr.patient;
      doctor  <= nbr.doctor;
    end else if (load) begin
      key     <= ctrl.key;
      patient <= ctrl.patient;
      doctor  <= ctrl.doctor;
    end
  end

  assign slot = '{valid: valid, key: key, patient: patient, doctor: doctor};

endmodule

`default_nettype wire

/* rtl/kfq_max_tree.sv */
// keyed fifo queue: registered max tree over the slot keys
// depends on kfq_pkg; one register level per tree level
`default_nettype none

module kfq_max_tree (
  input  wire logic                         clk,
  input  wire logic [kfq_pkg::KEY_BITS-1:0] leaf_keys [kfq_pkg::QUEUE_DEPTH],
  output logic      [kfq_pkg::KEY_BITS-1:0] max_key
);

  localparam int P = kfq_pkg::TREE_LEAVES;

  logic [kfq_pkg::KEY_BITS-1:0] leaf_pad [P];
  logic [kfq_pkg::KEY_BITS-1:0] node [1:P-1];

  genvar j, k;
  generate
    for (j = 0; j < P; j++) begin : g_leaf
      if (j < kfq_pkg::QUEUE_DEPTH) begin : g_real
        assign leaf_pad[j] = leaf_keys[j];
      end else begin : g_pad
        assign leaf_pad[j] = '0;
      end
    end

    // heap order: node k has children 2k and 2k+1
    for (k = 1; k < P; k++) begin : g_node
      if (2 * k >= P) begin : g_low
        always_ff @(posedge clk) begin
          node[k] <= kfq_pkg::key_max(leaf_pad[2*k-P], leaf_pad[2*k+1-P]);
        end
      end else begin : g_high
        always_ff @(posedge clk) begin
          node[k] <= kfq_pkg::key_max(node[2*k], node[2*k+1]);
        end
      end
    end
  endgenerate

  assign max_key = node[1];

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking bench for keyed_fifo_queue_core: directed and random command beats
// against a cycle-free queue predictor, with random sender bursts and receiver stalls
// depends on rtl/kfq_pkg.sv and rtl/keyed_fifo_queue_core.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // command codes the block ignores
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  localparam int RANDOM_BEATS   = 600;
  // idle cycles allowed with no beat on either side: longest sender gap plus the block
  // latency plus a long run of receiver stalls, many times over
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last result
  localparam int DRAIN_CYCLES   = 24;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] key;
    logic [15:0] patient;
    logic [15:0] doctor;
  } cmd_beat_t;

  typedef struct packed {
    logic             success;
    kfq_pkg::status_t status;
    logic [15:0]      head_key;
    logic [15:0]      head_patient;
    logic [15:0]      head_doctor;
    logic [16:0]      next_key;
    logic [4:0]       occupancy;
  } queue_result_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  // block ports, known from time zero
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [2:0]  command        = kfq_pkg::CMD_NEXT_ID;
  logic [15:0] entry_key      = '0;
  logic [15:0] patient_number = '0;
  logic [15:0] doctor_number  = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        success;
  logic [2:0]  status_code;
  logic [15:0] head_key;
  logic [15:0] head_patient;
  logic [15:0] head_doctor;
  logic [16:0] next_key;
  logic [4:0]  occupancy;

  keyed_fifo_queue_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .entry_key     (entry_key),
    .patient_number(patient_number),
    .doctor_number (doctor_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .success       (success),
    .status_code   (status_code),
    .head_key      (head_key),
    .head_patient  (head_patient),
    .head_doctor   (head_doctor),
    .next_key      (next_key),
    .occupancy     (occupancy)
  );

  // ---------------------------------------------------------------------------
  // queue predictor: mirror of the slot contents, head at index 0
  // ---------------------------------------------------------------------------
  logic [15:0] held_key     [kfq_pkg::QUEUE_DEPTH];
  logic [15:0] held_patient [kfq_pkg::QUEUE_DEPTH];
  logic [15:0] held_doctor  [kfq_pkg::QUEUE_DEPTH];
  int          held_count = 0;

  // remove one entry and close the gap, keeping arrival order
  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_key[i]     = held_key[i + 1];
      held_patient[i] = held_patient[i + 1];
      held_doctor[i]  = held_doctor[i + 1];
    end
    held_count--;
  endfunction

  // applies one command to the mirror and returns the result beat it causes
  function automatic queue_result_t apply_command(input cmd_beat_t b);
    queue_result_t r;
    int            hit;
    logic [16:0]   top;
    r   = '0;
    r.status = kfq_pkg::ST_OK;
    hit = -1;
    if (b.cmd == kfq_pkg::CMD_INSERT || b.cmd == kfq_pkg::CMD_CANCEL) begin
      for (int i = 0; i < held_count; i++) begin
        if (held_key[i] == b.key && hit < 0) hit = i;
      end
    end
    case (b.cmd)
      kfq_pkg::CMD_INSERT: begin
        // duplicate wins over full
        if (hit >= 0) begin
          r.status = kfq_pkg::ST_DUPLICATE;
        end else if (held_count >= kfq_pkg::QUEUE_DEPTH) begin
          r.status = kfq_pkg::ST_FULL;
        end else begin
          held_key[held_count]     = b.key;
          held_patient[held_count] = b.patient;
          held_doctor[held_count]  = b.doctor;
          held_count++;
          r.success = 1'b1;
        end
      end
      kfq_pkg::CMD_CANCEL: begin
        if (hit >= 0) begin
          drop_entry(hit);
          r.success = 1'b1;
        end else begin
          r.status = kfq_pkg::ST_NOT_FOUND;
        end
      end
      kfq_pkg::CMD_PEEK, kfq_pkg::CMD_SERVE: begin
        if (held_count == 0) begin
          r.status = kfq_pkg::ST_EMPTY;
        end else begin
          r.head_key     = held_key[0];
          r.head_patient = held_patient[0];
          r.head_doctor  = held_doctor[0];
          if (b.cmd == kfq_pkg::CMD_SERVE) drop_entry(0);
          r.success = 1'b1;
        end
      end
      kfq_pkg::CMD_CLEAR: begin
        held_count = 0;
        r.success  = 1'b1;
      end
      kfq_pkg::CMD_NEXT_ID: r.success = 1'b1;
      default: ;
    endcase
    // next key comes from the queue as it stands after the command
    top = '0;
    for (int i = 0; i < held_count; i++) begin
      if ({1'b0, held_key[i]} > top) top = {1'b0, held_key[i]};
    end
    r.next_key  = top + 17'd1;
    r.occupancy = 5'(held_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus store and result scoreboard
  // ---------------------------------------------------------------------------
  cmd_beat_t     pending_beats [$];
  queue_result_t awaited_results [$];
  int            mismatches = 0;

  task automatic push_beat(input logic [2:0] cmd, input logic [15:0] key,
                           input logic [15:0] patient, input logic [15:0] doctor);
    cmd_beat_t b;
    b.cmd     = cmd;
    b.key     = key;
    b.patient = patient;
    b.doctor  = doctor;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of beats with random gaps between them
  // ---------------------------------------------------------------------------
  cmd_beat_t cur_beat;
  int        burst_left = 8;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // beat taken at this edge: predict its result now, in accept order
      if (in_valid && !in_stall)
        awaited_results.insert(awaited_results.size(), apply_command(cur_beat));
      // a stalled beat holds; otherwise pick the next beat or idle
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat       = pending_beats[0];
          pending_beats.delete(0);
          command        <= cur_beat.cmd;
          entry_key      <= cur_beat.key;
          patient_number <= cur_beat.patient;
          doctor_number  <= cur_beat.doctor;
          in_valid       <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // about a third of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern: modes that last a random number of cycles
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;
  int          stall_period = 4;
  int          stall_phase  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode   = stall_mode_t'($urandom_range(0, 3));
        stall_left   = $urandom_range(16, 200);
        stall_period = $urandom_range(2, 9);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 85);
        default:     out_stall <= ((stall_phase % stall_period) < (stall_period / 2));
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [16:0] want,
                                      input logic [16:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result beat with none expected, expected none, actual status %0h",
                 $time, status_code);
        mismatches++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        check_field("success",      want.success,      success);
        check_field("status_code",  want.status,       status_code);
        check_field("head_key",     want.head_key,     head_key);
        check_field("head_patient", want.head_patient, head_patient);
        check_field("head_doctor",  want.head_doctor,  head_doctor);
        check_field("next_key",     want.next_key,     next_key);
        check_field("occupancy",    want.occupancy,    occupancy);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no beat on either channel ends the run
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, idle_cycles);
      $display("** keyed_fifo_queue_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] key_pool [$];
    cmd_beat_t   b;
    int          pool_size;
    int          insert_weight;
    int          phase_len;
    int          pick;
    int          counted;

    // empty queue: next id of 1, peek, serve and cancel all miss
    push_beat(kfq_pkg::CMD_NEXT_ID, 16'h0000, 16'h0000, 16'h0000);
    push_beat(kfq_pkg::CMD_PEEK,    16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_beat(kfq_pkg::CMD_SERVE,   16'h0000, 16'h0000, 16'h0000);
    push_beat(kfq_pkg::CMD_CANCEL,  16'h1234, 16'h0000, 16'h0000);
    // fill to the brim; head is the all-ones key so next key reaches 17 bits
    push_beat(kfq_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_beat(kfq_pkg::CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF);
    for (int i = 2; i < kfq_pkg::QUEUE_DEPTH; i++)
      push_beat(kfq_pkg::CMD_INSERT, 16'h5A00 + 16'(i), 16'(i * 16'h0111), 16'(~i));
    // full with a new key, then full with a held key (duplicate checked first)
    push_beat(kfq_pkg::CMD_INSERT, 16'hABCD, 16'h1111, 16'h2222);
    push_beat(kfq_pkg::CMD_INSERT, 16'h0000, 16'h3333, 16'h4444);
    // cancel from the middle, then serve the head
    push_beat(kfq_pkg::CMD_CANCEL, 16'h5A07, 16'h0000, 16'h0000);
    push_beat(kfq_pkg::CMD_SERVE,  16'h0000, 16'h0000, 16'h0000);
    // unused codes change nothing
    push_beat(CMD_RSVD_6, 16'h0000, 16'h0000, 16'h0000);
    push_beat(CMD_RSVD_7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_beat(kfq_pkg::CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000);

    // random phases: each has its own key pool and insert bias, so some phases
    // fill the queue and run into duplicates and full, others drain it
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      pool_size     = $urandom_range(4, 40);
      insert_weight = $urandom_range(25, 75);
      phase_len     = $urandom_range(20, 80);
      key_pool.delete();
      repeat (pool_size) begin
        if ($urandom_range(0, 9) == 0)
          key_pool.insert(key_pool.size(), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        else
          key_pool.insert(key_pool.size(), 16'($urandom));
      end
      repeat (phase_len) begin
        b.key     = 16'($urandom);
        b.patient = 16'($urandom);
        b.doctor  = 16'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < insert_weight) begin
          b.cmd = kfq_pkg::CMD_INSERT;
          if ($urandom_range(0, 9) != 0) b.key = key_pool[$urandom_range(0, pool_size - 1)];
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 35) begin
            b.cmd = kfq_pkg::CMD_CANCEL;
            if ($urandom_range(0, 4) != 0) b.key = key_pool[$urandom_range(0, pool_size - 1)];
          end else if (pick < 50) begin
            b.cmd = kfq_pkg::CMD_PEEK;
          end else if (pick < 80) begin
            b.cmd = kfq_pkg::CMD_SERVE;
          end else if (pick < 90) begin
            b.cmd = kfq_pkg::CMD_NEXT_ID;
          end else if (pick < 95) begin
            b.cmd = kfq_pkg::CMD_CLEAR;
          end else begin
            b.cmd = pick[0] ? CMD_RSVD_7 : CMD_RSVD_6;
          end
        end
        pending_beats.insert(pending_beats.size(), b);
        if (b.cmd != CMD_RSVD_6 && b.cmd != CMD_RSVD_7) counted++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all beats sent and every result back; the watchdog bounds this wait
    while (pending_beats.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    // catch any stray result beats
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** keyed_fifo_queue_core: PASSED **");
    end else begin
      $display("** keyed_fifo_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
